// ===== hw/rtl/rqs_pkg.sv =====
// Shared types, register codes and key compare for the record quicksort block.
`timescale 1ns / 1ps
`default_nettype none

package rqs_pkg;

    // Input request: one record, last_in closes the set
    typedef struct packed {
        logic [15:0] record_tag;
        logic [6:0]  rating_tenths;
        logic [11:0] launch_year;
        logic [9:0]  duration_minutes;
        logic        last_in;
    } in_req_t;

    // Output request: one record in sorted order
    typedef struct packed {
        logic [15:0] out_tag;
        logic [6:0]  out_rating_tenths;
        logic [11:0] out_year;
        logic [9:0]  out_duration;
        logic        last_out;
    } out_rsp_t;

    // Stored record (45 bits)
    typedef struct packed {
        logic [15:0] tag;
        logic [6:0]  rating;
        logic [11:0] year;
        logic [9:0]  duration;
    } rec_t;

    // Sort key codes
    typedef enum logic [1:0] {
        KEY_RATING   = 2'd0,
        KEY_YEAR     = 2'd1,
        KEY_DURATION = 2'd2,
        KEY_NONE     = 2'd3
    } sort_key_t;

    // Settings handed from the register file to the core
    typedef struct packed {
        sort_key_t sort_key;
    } core_cfg_t;

    // APB address width and register index codes (index = paddr[2])
    localparam int   APB_AW       = 3;
    localparam logic REG_SORT_KEY = 1'b0;

    // Strict less-than on the selected key; the "none" key never orders
    function automatic logic key_less(rec_t a, rec_t b, sort_key_t k);
        logic lt;
        begin
            case (k)
                KEY_RATING:   lt = (a.rating < b.rating);
                KEY_YEAR:     lt = (a.year < b.year);
                KEY_DURATION: lt = (a.duration < b.duration);
                default:      lt = 1'b0;
            endcase
            return lt;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/record_quicksort_by_key_top.sv =====
// Top level of the record quicksort block: APB register file and sort core.
//
//  channel   | signals                        | direction | moves
//  ----------+--------------------------------+-----------+--------------------------
//  input     | in_valid / in_ready / in_data  | in        | one record request
//  output    | out_valid / out_ready/out_data | out       | one sorted record request
//  config    | psel penable pwrite paddr ...  | in/out    | sort_key register
//
// Loading takes one record per cycle. The sort then runs on the record store:
// each compared element is read and checked, each swap adds two store writes,
// and each partitioned range adds a stack pop, pivot read, final swap and pushes.
// Emission reads each record from the store, then loads the output register.
// Reset clears the sequencer, counts and output valid; memories are not
// cleared. A stalled output holds the sequencer in the emit step.
`timescale 1ns / 1ps
`default_nettype none

module record_quicksort_by_key_top
    import rqs_pkg::*;
#(
    parameter int MAX_RECORDS = 64
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_req_t           in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_rsp_t               out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    sort_key_t sort_key_reg, sort_key_next;
    core_cfg_t cfg;
    logic      reg_idx;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = '{sort_key: sort_key_reg};

    // Register write decode
    always_comb
    begin
        sort_key_next = sort_key_reg;
        if (wr_en && reg_idx == REG_SORT_KEY)
            sort_key_next = sort_key_t'(pwdata[1:0]);
    end

    // Register readback
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_SORT_KEY)
            prdata = {30'd0, sort_key_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sort_key_reg <= KEY_RATING;
        else
            sort_key_reg <= sort_key_next;
    end

    rqs_core #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rqs_core.sv =====
// Record store, range stack and the partition/emit sequencer.
`timescale 1ns / 1ps
`default_nettype none

module rqs_core
    import rqs_pkg::*;
#(
    parameter int MAX_RECORDS = 64
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire core_cfg_t cfg,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_req_t   in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_rsp_t       out_data
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RECORDS);

    typedef struct packed {
        logic [AW-1:0] lo;
        logic [AW-1:0] hi;
    } range_t;

    typedef enum logic [14:0] {
        S_LOAD  = 15'b000000000000001,
        S_INIT  = 15'b000000000000010,
        S_POP   = 15'b000000000000100,
        S_POPW  = 15'b000000000001000,
        S_PIV   = 15'b000000000010000,
        S_RDJ   = 15'b000000000100000,
        S_CMP   = 15'b000000001000000,
        S_SW1   = 15'b000000010000000,
        S_SW2   = 15'b000000100000000,
        S_FSW1  = 15'b000001000000000,
        S_FSW2  = 15'b000010000000000,
        S_PUSHR = 15'b000100000000000,
        S_PUSHL = 15'b001000000000000,
        S_ERD   = 15'b010000000000000,
        S_EOUT  = 15'b100000000000000
    } state_t;

    // Memories
    rec_t   store_mem [MAX_RECORDS];
    range_t stack_mem [MAX_RECORDS];

    // Control and working registers
    state_t        state_reg,     state_next;
    logic [CW-1:0] count_reg,     count_next;
    logic [CW-1:0] sp_reg,        sp_next;
    logic [AW-1:0] lo_reg,        lo_next;
    logic [AW-1:0] hi_reg,        hi_next;
    logic [AW-1:0] j_reg,         j_next;
    logic [AW-1:0] slot_reg,      slot_next;
    rec_t          pivot_reg,     pivot_next;
    rec_t          tmp_reg,       tmp_next;
    logic          out_valid_reg, out_valid_next;
    out_rsp_t      out_data_reg,  out_data_next;

    // Memory ports
    logic          st_we, st_re;
    logic [AW-1:0] st_waddr, st_raddr;
    rec_t          st_wdata;
    rec_t          st_rdata_reg;
    logic          sk_we, sk_re;
    logic [AW-1:0] sk_waddr, sk_raddr;
    range_t        sk_wdata;
    range_t        sk_rdata_reg;

    rec_t          in_rec;
    logic          out_free;
    logic          is_last;

    assign in_rec    = '{tag: in_data.record_tag, rating: in_data.rating_tenths,
                         year: in_data.launch_year, duration: in_data.duration_minutes};
    assign in_ready  = (state_reg == S_LOAD);
    assign out_free  = !out_valid_reg || out_ready;
    assign is_last   = (CW'(j_reg) == (count_reg - CW'(1)));
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sp_next        = sp_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        j_next         = j_reg;
        slot_next      = slot_reg;
        pivot_next     = pivot_reg;
        tmp_next       = tmp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        st_we    = 1'b0;
        st_waddr = j_reg;
        st_wdata = st_rdata_reg;
        st_re    = 1'b0;
        st_raddr = j_reg;
        sk_we    = 1'b0;
        sk_waddr = sp_reg[AW-1:0];
        sk_wdata = '{lo: lo_reg, hi: hi_reg};
        sk_re    = 1'b0;
        sk_raddr = sp_reg[AW-1:0] - AW'(1);

        case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        st_we      = 1'b1;
                        st_waddr   = count_reg[AW-1:0];
                        st_wdata   = in_rec;
                        count_next = count_reg + CW'(1);
                    end
                    if (in_data.last_in)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                j_next = '0;
                if (count_reg < CW'(2))
                    state_next = S_ERD;
                else
                begin
                    sk_we      = 1'b1;
                    sk_waddr   = '0;
                    sk_wdata   = '{lo: '0, hi: AW'(count_reg - CW'(1))};
                    sp_next    = CW'(1);
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    j_next     = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    sk_re      = 1'b1;
                    sp_next    = sp_reg - CW'(1);
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                lo_next    = sk_rdata_reg.lo;
                hi_next    = sk_rdata_reg.hi;
                st_re      = 1'b1;
                st_raddr   = sk_rdata_reg.hi;
                state_next = S_PIV;
            end
            S_PIV:
            begin
                pivot_next = st_rdata_reg;
                j_next     = lo_reg;
                slot_next  = lo_reg;
                state_next = S_RDJ;
            end
            S_RDJ:
            begin
                if (j_reg == hi_reg)
                begin
                    if (slot_reg == hi_reg)
                        state_next = S_PUSHR;
                    else
                    begin
                        st_re      = 1'b1;
                        st_raddr   = slot_reg;
                        state_next = S_FSW1;
                    end
                end
                else
                begin
                    st_re      = 1'b1;
                    st_raddr   = j_reg;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (key_less(st_rdata_reg, pivot_reg, cfg.sort_key))
                begin
                    if (slot_reg == j_reg)
                    begin
                        slot_next  = slot_reg + AW'(1);
                        j_next     = j_reg + AW'(1);
                        state_next = S_RDJ;
                    end
                    else
                    begin
                        tmp_next   = st_rdata_reg;
                        st_re      = 1'b1;
                        st_raddr   = slot_reg;
                        state_next = S_SW1;
                    end
                end
                else
                begin
                    j_next     = j_reg + AW'(1);
                    state_next = S_RDJ;
                end
            end
            S_SW1:
            begin
                // old slot entry moves up to j
                st_we      = 1'b1;
                st_waddr   = j_reg;
                st_wdata   = st_rdata_reg;
                state_next = S_SW2;
            end
            S_SW2:
            begin
                st_we      = 1'b1;
                st_waddr   = slot_reg;
                st_wdata   = tmp_reg;
                slot_next  = slot_reg + AW'(1);
                j_next     = j_reg + AW'(1);
                state_next = S_RDJ;
            end
            S_FSW1:
            begin
                st_we      = 1'b1;
                st_waddr   = hi_reg;
                st_wdata   = st_rdata_reg;
                state_next = S_FSW2;
            end
            S_FSW2:
            begin
                st_we      = 1'b1;
                st_waddr   = slot_reg;
                st_wdata   = pivot_reg;
                state_next = S_PUSHR;
            end
            S_PUSHR:
            begin
                // right part first so the left part pops first
                if ((CW'(hi_reg) - CW'(slot_reg)) >= CW'(2) && sp_reg < MAX_CNT)
                begin
                    sk_we    = 1'b1;
                    sk_wdata = '{lo: slot_reg + AW'(1), hi: hi_reg};
                    sp_next  = sp_reg + CW'(1);
                end
                state_next = S_PUSHL;
            end
            S_PUSHL:
            begin
                if ((CW'(slot_reg) - CW'(lo_reg)) >= CW'(2) && sp_reg < MAX_CNT)
                begin
                    sk_we    = 1'b1;
                    sk_wdata = '{lo: lo_reg, hi: slot_reg - AW'(1)};
                    sp_next  = sp_reg + CW'(1);
                end
                state_next = S_POP;
            end
            S_ERD:
            begin
                if (out_free)
                begin
                    st_re      = 1'b1;
                    st_raddr   = j_reg;
                    state_next = S_EOUT;
                end
            end
            S_EOUT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '{out_tag: st_rdata_reg.tag,
                                   out_rating_tenths: st_rdata_reg.rating,
                                   out_year: st_rdata_reg.year,
                                   out_duration: st_rdata_reg.duration,
                                   last_out: is_last};
                if (is_last)
                begin
                    count_next = '0;
                    sp_next    = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    j_next     = j_reg + AW'(1);
                    state_next = S_ERD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        j_reg        <= j_next;
        slot_reg     <= slot_next;
        pivot_reg    <= pivot_next;
        tmp_reg      <= tmp_next;
        out_data_reg <= out_data_next;
    end

    // Record store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        if (st_re)
            st_rdata_reg <= store_mem[st_raddr];
    end

    // Range stack: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (sk_we)
            stack_mem[sk_waddr] <= sk_wdata;
        if (sk_re)
            sk_rdata_reg <= stack_mem[sk_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rqs_port_chk.sv =====
// Port-level checks for the record quicksort block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rqs_port_chk
    import rqs_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_ready,
    input wire in_req_t  in_data,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire out_rsp_t out_data
);

    // Stalled output request holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output request changed while stalled");

    // Closing record stops loading while the set is sorted
    a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_in |=> !in_ready)
        else $error("input still ready after closing record");

    // Output only appears out of the sort/emit phase
    a_out_after_sort: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("output request raised while loading");

    // Taking the final record leaves a gap before any further output
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_out |=> !out_valid)
        else $error("output request right after final record");

endmodule

bind record_quicksort_by_key_top rqs_port_chk u_port_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== bench/tb_record_quicksort_by_key_top.sv =====
// Self-checking testbench for the record quicksort block: directed table, then random record sets.
`timescale 1ns / 1ps

module tb_record_quicksort_by_key_top;
    import rqs_pkg::*;

    localparam int MAX_RECORDS   = 64;
    localparam int RANDOM_ITEMS  = 160;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int BIG_SET       = 68;

    localparam logic [APB_AW-1:0] ADDR_SORT_KEY = APB_AW'(0);
    localparam logic [APB_AW-1:0] ADDR_SPARE    = APB_AW'(4);

    // One step of the directed table: a register write or one record request
    typedef struct {
        logic              is_cfg;
        logic [APB_AW-1:0] addr;
        logic [31:0]       wdata;
        in_req_t           req;
        logic              typed;
        out_rsp_t          exp;
    } step_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_req_t           in_data;
    logic              out_valid;
    logic              out_ready;
    out_rsp_t          out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Shadow copy of the sorter state
    rec_t        shadow_store [MAX_RECORDS];
    int unsigned shadow_count;
    int unsigned lo_stack [MAX_RECORDS];
    int unsigned hi_stack [MAX_RECORDS];
    int unsigned stack_depth;
    sort_key_t   shadow_key;
    out_rsp_t    sorted_due [$];

    int       fail_count;
    int       records_sent;
    int       results_checked;
    int       sets_closed;
    int       long_holds;
    int       burst_left;
    bit [3:0] keys_seen;
    bit       want_long_hold;

    record_quicksort_by_key_top #(
        .MAX_RECORDS (MAX_RECORDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Strict less-than on the selected key; "none" never orders
    function automatic bit orders_before(rec_t a, rec_t b);
        case (shadow_key)
            KEY_RATING:   return a.rating < b.rating;
            KEY_YEAR:     return a.year < b.year;
            KEY_DURATION: return a.duration < b.duration;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic void swap_slots(int unsigned x, int unsigned y);
        rec_t t;
        t               = shadow_store[x];
        shadow_store[x] = shadow_store[y];
        shadow_store[y] = t;
    endfunction

    // Lomuto split: pivot is the last entry of the range
    function automatic int unsigned partition_range(int unsigned lo, int unsigned hi);
        rec_t        pivot;
        int unsigned slot;
        pivot = shadow_store[hi];
        slot  = lo;
        for (int unsigned j = lo; j < hi; j++)
        begin
            if (orders_before(shadow_store[j], pivot))
            begin
                swap_slots(slot, j);
                slot++;
            end
        end
        swap_slots(slot, hi);
        return slot;
    endfunction

    function automatic void push_span(int unsigned lo, int unsigned hi);
        if (lo < hi && stack_depth < MAX_RECORDS)
        begin
            lo_stack[stack_depth] = lo;
            hi_stack[stack_depth] = hi;
            stack_depth++;
        end
    endfunction

    // Store one accepted record; on the closing record sort and queue the sorted run
    function automatic void take_record(in_req_t r);
        int unsigned lo;
        int unsigned hi;
        int unsigned p;
        out_rsp_t    rsp;
        // a full store drops the record, but a closing flag still counts
        if (shadow_count < MAX_RECORDS)
        begin
            shadow_store[shadow_count].tag      = r.record_tag;
            shadow_store[shadow_count].rating   = r.rating_tenths;
            shadow_store[shadow_count].year     = r.launch_year;
            shadow_store[shadow_count].duration = r.duration_minutes;
            shadow_count++;
        end
        if (r.last_in)
        begin
            stack_depth = 0;
            if (shadow_count >= 2)
                push_span(0, shadow_count - 1);
            while (stack_depth > 0)
            begin
                stack_depth--;
                lo = lo_stack[stack_depth];
                hi = hi_stack[stack_depth];
                p  = partition_range(lo, hi);
                // right range pushed first so the left one runs first
                if (p < hi)
                    push_span(p + 1, hi);
                if (p > lo)
                    push_span(lo, p - 1);
            end
            for (int unsigned k = 0; k < shadow_count; k++)
            begin
                rsp.out_tag           = shadow_store[k].tag;
                rsp.out_rating_tenths = shadow_store[k].rating;
                rsp.out_year          = shadow_store[k].year;
                rsp.out_duration      = shadow_store[k].duration;
                rsp.last_out          = (k + 1 == shadow_count);
                sorted_due.push_back(rsp);
            end
            keys_seen[shadow_key] = 1'b1;
            shadow_count = 0;
            stack_depth  = 0;
            sets_closed++;
        end
    endfunction

    // Compare one accepted output request with the oldest expectation
    task automatic check_result(out_rsp_t got);
        out_rsp_t want;
        if (sorted_due.size() == 0)
        begin
            $error("unexpected sorted record, out_tag %0h", got.out_tag);
            fail_count++;
        end
        else
        begin
            want = sorted_due.pop_front();
            if (got.out_tag !== want.out_tag)
            begin
                $error("out_tag expected %0h actual %0h", want.out_tag, got.out_tag);
                fail_count++;
            end
            if (got.out_rating_tenths !== want.out_rating_tenths)
            begin
                $error("out_rating_tenths expected %0d actual %0d",
                       want.out_rating_tenths, got.out_rating_tenths);
                fail_count++;
            end
            if (got.out_year !== want.out_year)
            begin
                $error("out_year expected %0d actual %0d", want.out_year, got.out_year);
                fail_count++;
            end
            if (got.out_duration !== want.out_duration)
            begin
                $error("out_duration expected %0d actual %0d", want.out_duration, got.out_duration);
                fail_count++;
            end
            if (got.last_out !== want.last_out)
            begin
                $error("last_out expected %0b actual %0b", want.last_out, got.last_out);
                fail_count++;
            end
            results_checked++;
        end
    endtask

    // Drop valid, wait for every queued result, then let the core go idle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Idle-time register write followed by a read-back of sort_key
    task automatic reconfigure(logic [APB_AW-1:0] addr, logic [31:0] data);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // only index 0 is mapped
        if (addr == ADDR_SORT_KEY)
            shadow_key = sort_key_t'(data[1:0]);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SORT_KEY;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata[1:0] !== shadow_key)
        begin
            $error("sort_key readback expected %0d actual %0d", shadow_key, prdata[1:0]);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one record and hold it until accepted
    task automatic send_record(in_req_t r);
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        take_record(r);
        records_sent++;
    endtask

    // Sender bursts with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 15);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Random record; tie-prone sets draw keys from a few values
    function automatic in_req_t random_record(bit last, bit tie_prone);
        in_req_t r;
        r.record_tag = 16'($urandom_range(0, 65535));
        if (tie_prone)
        begin
            r.rating_tenths    = 7'($urandom_range(0, 2) * 50);
            r.launch_year      = 12'($urandom_range(2000, 2002));
            r.duration_minutes = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
        end
        else
        begin
            r.rating_tenths    = 7'($urandom_range(0, 100));
            r.launch_year      = 12'($urandom_range(0, 4095));
            r.duration_minutes = 10'($urandom_range(0, 1023));
        end
        r.last_in = last;
        return r;
    endfunction

    function automatic step_row_t rec_row(in_req_t r, logic typed, out_rsp_t e);
        step_row_t row;
        row.is_cfg = 1'b0;
        row.addr   = ADDR_SORT_KEY;
        row.wdata  = '0;
        row.req    = r;
        row.typed  = typed;
        row.exp    = e;
        return row;
    endfunction

    function automatic step_row_t cfg_row(logic [APB_AW-1:0] addr, logic [31:0] data);
        step_row_t row;
        row.is_cfg = 1'b1;
        row.addr   = addr;
        row.wdata  = data;
        row.req    = '0;
        row.typed  = 1'b0;
        row.exp    = '0;
        return row;
    endfunction

    // Receiver: checks results, stalls in random phases, one long hold on request
    initial
    begin : result_side
        int hold_left;
        int phase_left;
        int ready_pct;
        hold_left  = 0;
        phase_left = 0;
        ready_pct  = 100;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
                check_result(out_data);
            if (hold_left == 0 && want_long_hold && out_valid === 1'b1)
            begin
                hold_left      = LONG_HOLD;
                want_long_hold = 1'b0;
                long_holds++;
            end
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(20, 80);
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 75;
                    2:       ready_pct = 50;
                    default: ready_pct = 25;
                endcase
            end
            phase_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // Stimulus: directed table, random sets, drain and verdict
    initial
    begin : stimulus
        step_row_t dir_rows [$];
        int        set_size;
        int        set_idx;
        int        random_sent;
        bit        tie_prone;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        shadow_count    = 0;
        stack_depth     = 0;
        shadow_key      = KEY_RATING;
        fail_count      = 0;
        records_sent    = 0;
        results_checked = 0;
        sets_closed     = 0;
        long_holds      = 0;
        burst_left      = 0;
        keys_seen       = '0;
        want_long_hold  = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-record sets after reset: high-end and all-zero extremes echo back
        dir_rows.push_back(rec_row({16'hFFFF, 7'd100, 12'd4095, 10'd1023, 1'b1}, 1'b1,
                                   {16'hFFFF, 7'd100, 12'd4095, 10'd1023, 1'b1}));
        dir_rows.push_back(rec_row({16'h0000, 7'd0, 12'd0, 10'd0, 1'b1}, 1'b1,
                                   {16'h0000, 7'd0, 12'd0, 10'd0, 1'b1}));
        // rating key with a tie
        dir_rows.push_back(rec_row({16'h0001, 7'd50, 12'd1999, 10'd90, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0002, 7'd0, 12'd2020, 10'd120, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0003, 7'd100, 12'd1980, 10'd60, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0004, 7'd50, 12'd2001, 10'd100, 1'b1}, 1'b0, '0));
        // year key
        dir_rows.push_back(cfg_row(ADDR_SORT_KEY, 32'(KEY_YEAR)));
        dir_rows.push_back(rec_row({16'h0010, 7'd70, 12'd4095, 10'd30, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0011, 7'd20, 12'd0, 10'd45, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0012, 7'd90, 12'd2000, 10'd500, 1'b1}, 1'b0, '0));
        // duration key
        dir_rows.push_back(cfg_row(ADDR_SORT_KEY, 32'(KEY_DURATION)));
        dir_rows.push_back(rec_row({16'h0020, 7'd10, 12'd1990, 10'd1023, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0021, 7'd40, 12'd1991, 10'd0, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0022, 7'd10, 12'd1992, 10'd512, 1'b1}, 1'b0, '0));
        // no key: compares never succeed, order comes from the swaps alone
        dir_rows.push_back(cfg_row(ADDR_SORT_KEY, 32'(KEY_NONE)));
        dir_rows.push_back(rec_row({16'h0030, 7'd30, 12'd100, 10'd7, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0031, 7'd20, 12'd200, 10'd8, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0032, 7'd10, 12'd300, 10'd9, 1'b1}, 1'b0, '0));
        // write to an unmapped index is ignored: key stays none
        dir_rows.push_back(cfg_row(ADDR_SPARE, 32'(KEY_YEAR)));
        dir_rows.push_back(rec_row({16'h0040, 7'd99, 12'd4000, 10'd1, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0041, 7'd1, 12'd1, 10'd1000, 1'b1}, 1'b0, '0));
        // upper value bits are masked off: back to rating, all ratings equal
        dir_rows.push_back(cfg_row(ADDR_SORT_KEY, 32'hFFFF_FFFC));
        dir_rows.push_back(rec_row({16'h0050, 7'd60, 12'd10, 10'd3, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0051, 7'd60, 12'd20, 10'd2, 1'b0}, 1'b0, '0));
        dir_rows.push_back(rec_row({16'h0052, 7'd60, 12'd30, 10'd1, 1'b1}, 1'b0, '0));

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                reconfigure(dir_rows[i].addr, dir_rows[i].wdata);
            else
            begin
                send_record(dir_rows[i].req);
                if (dir_rows[i].typed)
                    sorted_due[sorted_due.size() - 1] = dir_rows[i].exp;
                pace();
            end
        end

        // random sets; one overflows the store, two trigger a long output hold
        set_idx     = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (set_idx % 4 == 0)
                reconfigure(($urandom_range(0, 4) == 0) ? ADDR_SPARE : ADDR_SORT_KEY, $urandom);
            if (set_idx == 1 || set_idx == 6)
                want_long_hold = 1'b1;
            if (set_idx == 3)
                set_size = BIG_SET;
            else if ($urandom_range(0, 5) == 0)
                set_size = $urandom_range(10, 20);
            else
                set_size = $urandom_range(1, 8);
            tie_prone = ($urandom_range(0, 2) == 0);
            for (int k = 1; k <= set_size; k++)
            begin
                send_record(random_record(k == set_size, tie_prone));
                random_sent++;
                pace();
            end
            set_idx++;
        end

        wait_drained();
        $display("Covered %0d record sets (%0d records), %0d sorted records checked, keys used %b",
                 sets_closed, records_sent, results_checked, keys_seen);
        $display("Run included a %0d-record overflow set and %0d long output holds",
                 BIG_SET, long_holds);
        if (fail_count == 0 && sorted_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: ends the run with a failure verdict
    initial
    begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== record_quicksort_by_key_top.f =====
hw/rtl/rqs_pkg.sv
hw/rtl/rqs_core.sv
hw/rtl/record_quicksort_by_key_top.sv
hw/rtl/rqs_port_chk.sv
bench/tb_record_quicksort_by_key_top.sv
